FILE: hdl/esp_pkg.sv
// Package for the encoder speed PID block: state codes, register indexes, fixed widths and rate bounds.
package esp_pkg;

  // Fixed widths of the register and result fields.
  localparam int GAIN_W   = 16;
  localparam int RATE_W   = 24;
  localparam int SMOOTH_W = 9;
  localparam int LIMIT_W  = 15;
  localparam int DRIVE_W  = 16;
  localparam int ERR_W    = RATE_W + 1;
  localparam int DE_W     = RATE_W + 2;
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 32;

  // Saturation bounds of the filtered rate.
  localparam logic signed [RATE_W-1:0] RATE_MAX = 24'sh7FFFFF;
  localparam logic signed [RATE_W-1:0] RATE_MIN = 24'sh800000;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_I    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_TARGET    = 3'd3;
  localparam logic [2:0] REG_SMOOTHING = 3'd4;
  localparam logic [2:0] REG_DRIVE_LIM = 3'd5;
  localparam logic [2:0] REG_WINDUP    = 3'd6;

  // Sequencer steps of one control update.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MFILT,
    ST_FILT,
    ST_MP,
    ST_MI,
    ST_MD,
    ST_SUM
  } esp_state_t;

endpackage

FILE: hdl/encoder_speed_pid_top.sv
// Encoder speed PID controller: one shared multiplier under an eight-step sequencer.
//
//  Channel  Direction  Handshake                Contents
//  in_      slave      in_tvalid / in_tready    encoder_count
//  out_     master     out_tvalid / out_tready  drive, smoothed_rate
//  cfg_     APB slave  psel, penable, pready    seven control registers
//
// Each encoder sample passes through the accept cycle and seven sequencer steps,
// four of which feed the single multiplier (filter weight, P, I and D gains).
// in_tready is high only while the sequencer is idle.
// The result waits in an output register; the next sample is accepted meanwhile and
// its last step holds until that register is free.
// rst_n is synchronous and active low; it restores the register defaults and clears
// the controller state.
module encoder_speed_pid_top #(
  parameter int FRAC_BITS   = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input stream: tdata holds encoder_count in the low COUNT_WIDTH bits.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((COUNT_WIDTH+7)/8)*8-1:0]     in_tdata,
  // Result stream: tdata holds drive [15:0], smoothed_rate [39:16].
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [39:0]                          out_tdata,
  // Configuration port.
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [esp_pkg::APB_AW-1:0]           cfg_paddr,
  input  logic [esp_pkg::APB_DW-1:0]           cfg_pwdata,
  output logic [esp_pkg::APB_DW-1:0]           cfg_prdata,
  output logic                                 cfg_pready
);

  import esp_pkg::*;

  localparam int F      = FRAC_BITS;
  localparam int CW     = COUNT_WIDTH;
  localparam int DF_W   = ((CW + F > RATE_W) ? CW + F : RATE_W) + 1;
  localparam int D_W    = RATE_W + 3 + F;
  localparam int CMP_W  = ((DF_W > D_W) ? DF_W : D_W) + 1;
  localparam int MA     = D_W;
  localparam int MB     = (F + 1 > GAIN_W) ? F + 1 : GAIN_W;
  localparam int P_W    = MA + MB + 1;
  localparam int S_W    = P_W + 2;
  localparam int IA_W   = LIMIT_W + 1 + F;

  localparam logic signed [CMP_W-1:0] DBND =
    {{(CMP_W-1){1'b0}}, 1'b1} << (RATE_W + 1 + F);
  localparam logic signed [P_W-1:0] HALF_P = {{(P_W-1){1'b0}}, 1'b1} << (F - 1);
  localparam logic [31:0] ONE_Q = 32'd1 << F;

  // Control registers.
  logic [GAIN_W-1:0]          gain_p_r, gain_i_r, gain_d_r;
  logic signed [RATE_W-1:0]   target_r;
  logic [SMOOTH_W-1:0]        smooth_r;
  logic [LIMIT_W-1:0]         drive_lim_r, windup_r;

  // Controller state and datapath registers.
  esp_state_t                 state_r, state_nxt;
  logic [CW-1:0]              last_count_r, last_count_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic signed [RATE_W-1:0]   rf_r, rf_nxt;
  logic signed [IA_W-1:0]     ia_r, ia_nxt;
  logic signed [ERR_W-1:0]    last_err_r, last_err_nxt;
  logic signed [ERR_W-1:0]    err_r, err_nxt;
  logic signed [MA-1:0]       opa_r, opa_nxt;
  logic [MB-1:0]              opb_r, opb_nxt;
  logic signed [P_W-1:0]      prod_r, prod_nxt;
  logic signed [P_W-1:0]      pterm_r, pterm_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [DRIVE_W-1:0]  out_drive_r, out_drive_nxt;
  logic signed [RATE_W-1:0]   out_rate_r, out_rate_nxt;

  // Combinational helpers.
  logic signed [CW-1:0]       raw_s;
  logic signed [DF_W-1:0]     dfull;
  logic signed [CMP_W-1:0]    dx, dc;
  logic [MB-1:0]              alpha_v;
  logic signed [P_W-1:0]      fsum, fstep, fnew;
  logic signed [RATE_W-1:0]   rf_new;
  logic signed [ERR_W-1:0]    err_new;
  logic signed [DE_W-1:0]     de;
  logic signed [P_W-1:0]      ilim, isum, iclamp;
  logic signed [S_W-1:0]      ssum, slim, sclamp, smag, sq;
  logic                       cfg_wr;

  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rate_r, out_drive_r};

  // Shared multiplier: signed operand times unsigned gain or weight.
  assign prod_nxt = $signed(opa_r) * $signed({1'b0, opb_r});

  // Configuration registers, written on the access cycle of an APB write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= 16'd5120;
      gain_i_r    <= 16'd15360;
      gain_d_r    <= 16'd0;
      target_r    <= 24'sd5120;
      smooth_r    <= 9'd51;
      drive_lim_r <= 15'd1000;
      windup_r    <= 15'd300;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_GAIN_P:    gain_p_r    <= cfg_pwdata[GAIN_W-1:0];
        REG_GAIN_I:    gain_i_r    <= cfg_pwdata[GAIN_W-1:0];
        REG_GAIN_D:    gain_d_r    <= cfg_pwdata[GAIN_W-1:0];
        REG_TARGET:    target_r    <= cfg_pwdata[RATE_W-1:0];
        REG_SMOOTHING: smooth_r    <= cfg_pwdata[SMOOTH_W-1:0];
        REG_DRIVE_LIM: drive_lim_r <= cfg_pwdata[LIMIT_W-1:0];
        REG_WINDUP:    windup_r    <= cfg_pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_GAIN_P:    cfg_prdata = APB_DW'(gain_p_r);
      REG_GAIN_I:    cfg_prdata = APB_DW'(gain_i_r);
      REG_GAIN_D:    cfg_prdata = APB_DW'(gain_d_r);
      REG_TARGET:    cfg_prdata = APB_DW'(target_r);
      REG_SMOOTHING: cfg_prdata = APB_DW'(smooth_r);
      REG_DRIVE_LIM: cfg_prdata = APB_DW'(drive_lim_r);
      REG_WINDUP:    cfg_prdata = APB_DW'(windup_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // Control and controller state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      last_count_r <= '0;
      rf_r         <= '0;
      ia_r         <= '0;
      last_err_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      last_count_r <= last_count_nxt;
      rf_r         <= rf_nxt;
      ia_r         <= ia_nxt;
      last_err_r   <= last_err_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    count_r     <= count_nxt;
    err_r       <= err_nxt;
    opa_r       <= opa_nxt;
    opb_r       <= opb_nxt;
    prod_r      <= prod_nxt;
    pterm_r     <= pterm_nxt;
    out_drive_r <= out_drive_nxt;
    out_rate_r  <= out_rate_nxt;
  end

  // Datapath pieces used by the sequencer steps.
  always_comb begin
    // Wrapped count difference, scaled and clamped so the product stays narrow.
    raw_s = $signed(count_r - last_count_r);
    dfull = (DF_W'(raw_s) <<< F) - DF_W'(rf_r);
    dx    = CMP_W'(dfull);
    if (dx > DBND) begin
      dc = DBND;
    end else if (dx < -DBND) begin
      dc = -DBND;
    end else begin
      dc = dx;
    end

    // Filter weight, capped at unity.
    if ({{(32-SMOOTH_W){1'b0}}, smooth_r} > ONE_Q) begin
      alpha_v = MB'(ONE_Q);
    end else begin
      alpha_v = MB'(smooth_r);
    end

    // Filter update with round half up, then saturation to the rate range.
    fsum  = prod_r + HALF_P;
    fstep = fsum >>> F;
    fnew  = P_W'(rf_r) + fstep;
    if (fnew > P_W'(RATE_MAX)) begin
      rf_new = RATE_MAX;
    end else if (fnew < P_W'(RATE_MIN)) begin
      rf_new = RATE_MIN;
    end else begin
      rf_new = fnew[RATE_W-1:0];
    end
    err_new = ERR_W'(target_r) - ERR_W'(rf_new);

    // Error change for the derivative term.
    de = DE_W'(err_r) - DE_W'(last_err_r);

    // Integral update with floor shift and symmetric clamp.
    ilim = P_W'(windup_r) << F;
    isum = P_W'(ia_r) + (prod_r >>> F);
    if (isum > ilim) begin
      iclamp = ilim;
    end else if (isum < -ilim) begin
      iclamp = -ilim;
    end else begin
      iclamp = isum;
    end

    // Output sum, clamp and truncation toward zero.
    ssum = S_W'(pterm_r) + (S_W'(ia_r) <<< F) + S_W'(prod_r);
    slim = S_W'(drive_lim_r) << (2 * F);
    if (ssum > slim) begin
      sclamp = slim;
    end else if (ssum < -slim) begin
      sclamp = -slim;
    end else begin
      sclamp = ssum;
    end
    smag = sclamp[S_W-1] ? -sclamp : sclamp;
    sq   = smag >>> (2 * F);
    if (sclamp[S_W-1]) begin
      sq = -sq;
    end
  end

  // Sequencer: next state and register loads.
  always_comb begin
    state_nxt      = state_r;
    last_count_nxt = last_count_r;
    count_nxt      = count_r;
    rf_nxt         = rf_r;
    ia_nxt         = ia_r;
    last_err_nxt   = last_err_r;
    err_nxt        = err_r;
    opa_nxt        = opa_r;
    opb_nxt        = opb_r;
    pterm_nxt      = pterm_r;
    out_drive_nxt  = out_drive_r;
    out_rate_nxt   = out_rate_r;
    out_valid_nxt  = out_valid_r & ~out_tready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          count_nxt = in_tdata[CW-1:0];
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        last_count_nxt = count_r;
        opa_nxt        = MA'(dc);
        opb_nxt        = alpha_v;
        state_nxt      = ST_MFILT;
      end
      ST_MFILT: begin
        state_nxt = ST_FILT;
      end
      ST_FILT: begin
        rf_nxt    = rf_new;
        err_nxt   = err_new;
        opa_nxt   = MA'(err_new);
        opb_nxt   = MB'(gain_p_r);
        state_nxt = ST_MP;
      end
      ST_MP: begin
        opb_nxt   = MB'(gain_i_r);
        state_nxt = ST_MI;
      end
      ST_MI: begin
        // Product now holds the proportional term.
        pterm_nxt = prod_r;
        opa_nxt   = MA'(de);
        opb_nxt   = MB'(gain_d_r);
        state_nxt = ST_MD;
      end
      ST_MD: begin
        // Product now holds the integral increment before scaling.
        ia_nxt       = iclamp[IA_W-1:0];
        last_err_nxt = err_r;
        state_nxt    = ST_SUM;
      end
      ST_SUM: begin
        // Product holds the derivative term; wait for a free output register.
        if (!out_valid_r || out_tready) begin
          out_drive_nxt = sq[DRIVE_W-1:0];
          out_rate_nxt  = rf_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: verif/tb_encoder_speed_pid_top.sv
// Self-checking testbench for the encoder speed PID controller top level.
`timescale 1ns / 100ps

module tb_encoder_speed_pid_top;
  import esp_pkg::*;

  // Register index that decodes to no register.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // Expected contents of one result request.
  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic signed [RATE_W-1:0]  rate;
  } speed_cmd_t;

  // Scoreboard: mirrors the controller state and compares each result in order.
  class speed_pid_scoreboard;
    // Shadow copies of the control registers.
    logic [GAIN_W-1:0]        gain_p;
    logic [GAIN_W-1:0]        gain_i;
    logic [GAIN_W-1:0]        gain_d;
    logic signed [RATE_W-1:0] target;
    logic [SMOOTH_W-1:0]      smooth;
    logic [LIMIT_W-1:0]       drive_lim;
    logic [LIMIT_W-1:0]       windup_lim;
    // Controller state.
    logic [15:0]              prev_count;
    logic signed [RATE_W-1:0] filt_rate;
    longint                   integ;
    longint                   prev_err;
    speed_cmd_t               pending_cmds[$];
    int                       errors;
    int                       n_checked;

    function new();
      gain_p     = 16'd5120;
      gain_i     = 16'd15360;
      gain_d     = 16'd0;
      target     = 24'sd5120;
      smooth     = 9'd51;
      drive_lim  = 15'd1000;
      windup_lim = 15'd300;
      prev_count = '0;
      filt_rate  = '0;
      integ      = 0;
      prev_err   = 0;
      errors     = 0;
      n_checked  = 0;
    endfunction

    function void write_register(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_GAIN_P:    gain_p = value[15:0];
        REG_GAIN_I:    gain_i = value[15:0];
        REG_GAIN_D:    gain_d = value[15:0];
        REG_TARGET:    target = value[23:0];
        REG_SMOOTHING: smooth = value[8:0];
        REG_DRIVE_LIM: drive_lim = value[14:0];
        REG_WINDUP:    windup_lim = value[14:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_cmds.size();
    endfunction

    function void flag(string msg);
      if (errors < 10) begin
        $display("[%0t] ERROR: %s", $realtime, msg);
      end
      errors++;
    endfunction

    // One control update: wrapped speed, low-pass filter, then the PID law.
    function void note_sample(logic [15:0] count);
      logic [15:0] delta;
      longint      raw;
      longint      alpha;
      longint      filt;
      longint      err;
      longint      ilim;
      longint      sum;
      longint      lim;
      longint      drv;
      speed_cmd_t  cmd;
      delta      = count - prev_count;
      raw        = longint'($signed(delta));
      prev_count = count;

      // Smoothing weights above unity act as unity; the step rounds half up.
      alpha = (smooth > 9'd256) ? 256 : longint'(smooth);
      filt  = longint'(filt_rate);
      filt  = filt + ((alpha * (raw * 256 - filt) + 128) >>> 8);
      if (filt > 64'sd8388607) filt = 64'sd8388607;
      if (filt < -64'sd8388608) filt = -64'sd8388608;
      filt_rate = filt[23:0];

      err = longint'(target) - filt;

      // Integral with floor scaling, held inside the windup bound.
      ilim  = longint'(windup_lim) * 256;
      integ = integ + ((longint'(gain_i) * err) >>> 8);
      if (integ > ilim) integ = ilim;
      if (integ < -ilim) integ = -ilim;

      sum = longint'(gain_p) * err + integ * 256 + longint'(gain_d) * (err - prev_err);
      prev_err = err;

      // Clamp at full precision, then truncate toward zero.
      lim = longint'(drive_lim) * 65536;
      if (sum > lim) sum = lim;
      if (sum < -lim) sum = -lim;
      drv = (sum >= 0) ? (sum >>> 16) : -((-sum) >>> 16);

      cmd.drive = drv[15:0];
      cmd.rate  = filt_rate;
      pending_cmds.push_back(cmd);
    endfunction

    function void check_result(logic [39:0] data);
      speed_cmd_t want;
      if (pending_cmds.size() == 0) begin
        flag($sformatf("result %0d arrived with no request outstanding", n_checked));
        n_checked++;
        return;
      end
      want = pending_cmds.pop_front();
      if (data[15:0] !== want.drive) begin
        flag($sformatf("result %0d drive: expected %0d, got %0d",
                       n_checked, want.drive, $signed(data[15:0])));
      end
      if (data[39:16] !== want.rate) begin
        flag($sformatf("result %0d smoothed_rate: expected %0d, got %0d",
                       n_checked, want.rate, $signed(data[39:16])));
      end
      n_checked++;
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '0;   // encoder_count [15:0]
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [39:0] out_tdata;          // drive [15:0], smoothed_rate [39:16]
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [APB_AW-1:0] cfg_paddr  = '0;
  logic [APB_DW-1:0] cfg_pwdata = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic        cfg_pready;

  speed_pid_scoreboard board;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  logic [15:0] enc_pos        = '0;
  int          enc_speed      = 0;

  encoder_speed_pid_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Clock.
  always #2 clk = ~clk;

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_result(out_tdata);
    end
  end

  // Watchdog for a hung run.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Register write: setup cycle, access cycle, then the bus goes idle.
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    board.write_register(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_setting(input int kp, input int ki, input int kd, input int tgt,
                               input int sm, input int dl, input int wl);
    apb_write(REG_GAIN_P, kp);
    apb_write(REG_GAIN_I, ki);
    apb_write(REG_GAIN_D, kd);
    apb_write(REG_TARGET, tgt & 32'h00FF_FFFF);
    apb_write(REG_SMOOTHING, sm);
    apb_write(REG_DRIVE_LIM, dl);
    apb_write(REG_WINDUP, wl);
  endtask

  // Present one sample and hold it until the block takes the request.
  task automatic send_sample(input logic [15:0] count);
    in_tvalid <= 1'b1;
    in_tdata  <= count;
    do @(posedge clk); while (!in_tready);
    board.note_sample(count);
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic int pick_speed();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return int'($urandom_range(0, 100)) - 50;
      2:       return int'($urandom_range(0, 4000)) - 2000;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Mostly a steadily turning shaft with jitter; some wild jumps and half-turn wraps.
  function automatic logic [15:0] next_count();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) enc_speed = pick_speed();
    if (pick < 85) begin
      enc_pos = enc_pos + 16'(enc_speed) + 16'($urandom_range(0, 6)) - 16'd3;
    end else if (pick < 95) begin
      enc_pos = 16'($urandom);
    end else begin
      enc_pos = enc_pos + 16'h8000 + 16'($urandom_range(0, 2)) - 16'd1;
    end
    return enc_pos;
  endfunction

  function automatic int rand_gain();
    return $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 4096);
  endfunction

  // Control settings for each phase; the reset defaults come first, then the extremes.
  task automatic apply_phase(input int ph);
    case (ph)
      0: ; // reset defaults
      1: write_setting(65535, 65535, 65535, 8388607, 256, 32767, 32767);
      2: write_setting(0, 0, 0, -8388608, 0, 0, 0);
      3: begin
        write_setting(2560, 1024, 768, -2560, 511, 500, 200);
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
      end
      4: write_setting(5120, 15360, 2560, 5120, 51, 1000, 300);
      5: write_setting(65535, 65535, 65535, -8388608, 1, 32767, 0);
      default: write_setting(rand_gain(), rand_gain(), rand_gain(), int'($urandom),
                             $urandom_range(0, 511), $urandom_range(0, 32767),
                             $urandom_range(0, 32767));
    endcase
  endtask

  function automatic void set_idling(input int mode);
    case (mode)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 49; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 49; end
      default: begin send_idle_pct = 34; recv_stall_pct = 34; end
    endcase
  endfunction

  // Main sequence.
  initial begin
    logic [15:0] directed[20];
    directed = '{16'h8000, 16'h0000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h0000,
                 16'h0014, 16'h0028, 16'h003C, 16'h0050, 16'h0064, 16'h0078,
                 16'h008C, 16'h00A0, 16'h00A0, 16'h00A0, 16'h7FFF, 16'hFFFE,
                 16'h5555, 16'hAAAA};
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples at the reset settings, first one straight after reset.
    foreach (directed[k]) send_sample(directed[k]);
    enc_pos = directed[19];

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      apply_phase(ph);
      set_idling(ph % 4);
      enc_speed = pick_speed();
      for (int n = 0; n < 158; n++) begin
        if ($urandom_range(0, 99) < send_idle_pct) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        send_sample(next_count());
      end
    end

    // Let the last results out, then report.
    drain();
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/esp_pkg.sv
hdl/encoder_speed_pid_top.sv
verif/tb_encoder_speed_pid_top.sv
